// File: rtl/csbc_pkg.sv
// ----------------------------------------------------------------------------
// csbc_pkg
// Shared types, register map and time arithmetic helpers for the
// clock-setting button controller.
// ----------------------------------------------------------------------------
package csbc_pkg;

    // register map (byte address 4*index)
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_HOLD_TICKS  = 2'd0;
    localparam logic [1:0] REG_STEP_MILLIS = 2'd1;
    localparam logic [1:0] REG_STEP_MICROS = 2'd2;
    localparam logic [1:0] REG_STEP_NANOS  = 2'd3;

    localparam logic [7:0] HOLD_TICKS_RST  = 8'd38;
    localparam logic [9:0] STEP_MILLIS_RST = 10'd13;
    localparam logic [9:0] STEP_MICROS_RST = 10'd107;
    localparam logic [9:0] STEP_NANOS_RST  = 10'd200;

    localparam logic [9:0]  STEP_MAX      = 10'd999;
    localparam logic [10:0] SUB_LIMIT     = 11'd1000;
    localparam logic [9:0]  DOT_THRESHOLD = 10'd500;
    localparam logic [2:0]  ROUND_TENS    = 3'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic       hours_button;
        logic       minutes_button;
        logic [5:0] load_hours_bcd;
        logic [6:0] load_minutes_bcd;
    } t_in_item;

    typedef struct packed {
        logic [5:0] hours_bcd;
        logic [6:0] minutes_bcd;
        logic       dot_on;
        logic       write_hours;
        logic       write_minutes;
        logic       clear_seconds;
    } t_out_item;

    // one sub-second digit group: value plus carry out
    typedef struct packed {
        logic       carry;
        logic [9:0] value;
    } t_sub_sum;

    typedef struct packed {
        logic       fire;
        logic [7:0] count;
    } t_hold;

    function automatic logic [9:0] clamp_step(input logic [9:0] s);
        return (s > STEP_MAX) ? STEP_MAX : s;
    endfunction

    // acc < 1000 and step <= 999, so one subtract covers the wrap
    function automatic t_sub_sum sub_add(input logic [9:0] acc,
                                         input logic [9:0] step,
                                         input logic       cin);
        logic [10:0] sum;
        t_sub_sum    res;
        sum = {1'b0, acc} + {1'b0, clamp_step(step)} + {10'd0, cin};
        if (sum >= SUB_LIMIT) begin
            sum       = sum - SUB_LIMIT;
            res.carry = 1'b1;
        end else begin
            res.carry = 1'b0;
        end
        res.value = sum[9:0];
        return res;
    endfunction

    function automatic logic [5:0] next_hours(input logic [5:0] h);
        logic [1:0] tens;
        logic [3:0] ones;
        logic [5:0] res;
        tens = h[5:4];
        ones = h[3:0];
        if (tens == 2'd3 || (tens == 2'd2 && ones >= 4'd3)) begin
            res = 6'd0;
        end else if (ones >= 4'd9) begin
            res = {tens + 2'd1, 4'd0};
        end else begin
            res = {tens, ones + 4'd1};
        end
        return res;
    endfunction

    function automatic logic [6:0] next_minutes(input logic [6:0] m);
        logic [2:0] tens;
        logic [3:0] ones;
        logic [6:0] res;
        tens = m[6:4];
        ones = m[3:0];
        if (tens >= 3'd6 || (tens == 3'd5 && ones >= 4'd9)) begin
            res = 7'd0;
        end else if (ones >= 4'd9) begin
            res = {tens + 3'd1, 4'd0};
        end else begin
            res = {tens, ones + 4'd1};
        end
        return res;
    endfunction

    // one held tick of an auto-repeat counter
    function automatic t_hold hold_tick(input logic [7:0] count,
                                        input logic [7:0] hold);
        logic [7:0] c;
        t_hold      res;
        c = count + 8'd1;
        if (c >= hold) begin
            res.fire  = 1'b1;
            res.count = c - hold;
        end else begin
            res.fire  = 1'b0;
            res.count = c;
        end
        return res;
    endfunction

endpackage

// File: rtl/csbc_stream_if.sv
// ----------------------------------------------------------------------------
// csbc_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface csbc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/clock_set_button_controller_top.sv
// ----------------------------------------------------------------------------
// clock_set_button_controller_top
// Clock-setting controller: sub-second accumulator, button auto-repeat,
// correction and time load, with an APB-style register port.
// ----------------------------------------------------------------------------
// Each input transaction is either a tick (advances the ms/us/ns accumulator
// by the programmed steps and samples the hours and minutes buttons) or a load
// (copies BCD hours and minutes from the clock chip). Every input transaction
// produces exactly one result transaction holding the BCD time, the half-second
// dot and the write-back flags. The block takes one transaction per clock while
// i_in.ready is high: the whole update is one pass of logic from the accepted
// input into the state registers and the output register, so a result appears
// in the cycle after its input is accepted. The output register decouples the
// channels: i_in.ready is high whenever the output register is empty or is
// being drained in the same cycle. Registers: 0x0 hold_ticks, 0x4 step_millis,
// 0x8 step_micros, 0xC step_nanos; write them only while the block is idle.
// ----------------------------------------------------------------------------
module clock_set_button_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    csbc_stream_if.sink                         i_in,
    csbc_stream_if.source                       o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csbc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [csbc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [csbc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import csbc_pkg::*;

    // configuration registers
    logic [7:0] r_hold_ticks;
    logic [9:0] r_step_millis;
    logic [9:0] r_step_micros;
    logic [9:0] r_step_nanos;

    // time state
    logic [9:0] r_sub_millis,   n_sub_millis;
    logic [9:0] r_sub_micros,   n_sub_micros;
    logic [9:0] r_sub_nanos,    n_sub_nanos;
    logic [5:0] r_cur_hours,    n_cur_hours;
    logic [6:0] r_cur_minutes,  n_cur_minutes;
    logic [7:0] r_hours_hold,   n_hours_hold;
    logic [7:0] r_minutes_hold, n_minutes_hold;
    logic [7:0] r_both_hold,    n_both_hold;

    // output stage
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item,  n_out_item;

    logic     in_fire;
    logic     cfg_write;
    logic [1:0] cfg_index;
    t_in_item in_item;
    t_sub_sum ns_sum, us_sum, ms_sum;
    t_hold    both_step, hours_step, minutes_step;
    logic     wr_h, wr_m, clr_s;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks  <= HOLD_TICKS_RST;
            r_step_millis <= STEP_MILLIS_RST;
            r_step_micros <= STEP_MICROS_RST;
            r_step_nanos  <= STEP_NANOS_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_HOLD_TICKS:  r_hold_ticks  <= pwdata[7:0];
                REG_STEP_MILLIS: r_step_millis <= pwdata[9:0];
                REG_STEP_MICROS: r_step_micros <= pwdata[9:0];
                REG_STEP_NANOS:  r_step_nanos  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_HOLD_TICKS:  prdata = {24'd0, r_hold_ticks};
            REG_STEP_MILLIS: prdata = {22'd0, r_step_millis};
            REG_STEP_MICROS: prdata = {22'd0, r_step_micros};
            REG_STEP_NANOS:  prdata = {22'd0, r_step_nanos};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: accept while the output register is free or draining
    // ------------------------------------------------------------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_item    = i_in.payload;

    // sub-second accumulator chain, ns carries into us carries into ms
    assign ns_sum = sub_add(r_sub_nanos,  r_step_nanos,  1'b0);
    assign us_sum = sub_add(r_sub_micros, r_step_micros, ns_sum.carry);
    assign ms_sum = sub_add(r_sub_millis, r_step_millis, us_sum.carry);

    // auto-repeat counters
    assign both_step    = hold_tick(r_both_hold,    r_hold_ticks);
    assign hours_step   = hold_tick(r_hours_hold,   r_hold_ticks);
    assign minutes_step = hold_tick(r_minutes_hold, r_hold_ticks);

    always_comb begin
        n_sub_millis   = r_sub_millis;
        n_sub_micros   = r_sub_micros;
        n_sub_nanos    = r_sub_nanos;
        n_cur_hours    = r_cur_hours;
        n_cur_minutes  = r_cur_minutes;
        n_hours_hold   = r_hours_hold;
        n_minutes_hold = r_minutes_hold;
        n_both_hold    = r_both_hold;
        wr_h           = 1'b0;
        wr_m           = 1'b0;
        clr_s          = 1'b0;

        if (in_fire) begin
            if (in_item.opcode == OP_LOAD) begin
                n_cur_hours   = in_item.load_hours_bcd;
                n_cur_minutes = in_item.load_minutes_bcd;
            end else begin
                n_sub_nanos  = ns_sum.value;
                n_sub_micros = us_sum.value;
                n_sub_millis = ms_sum.value;

                if (in_item.hours_button && in_item.minutes_button) begin
                    // correction: round to the hour, clear seconds
                    n_both_hold = both_step.count;
                    if (both_step.fire) begin
                        if (r_cur_minutes[6:4] >= ROUND_TENS) begin
                            n_cur_hours = next_hours(r_cur_hours);
                            wr_h        = 1'b1;
                        end
                        n_cur_minutes = 7'd0;
                        wr_m          = 1'b1;
                        clr_s         = 1'b1;
                        n_sub_millis  = 10'd0;
                        n_sub_micros  = 10'd0;
                        n_sub_nanos   = 10'd0;
                    end
                end else begin
                    n_both_hold = 8'd0;
                    if (in_item.hours_button) begin
                        n_hours_hold = hours_step.count;
                        if (hours_step.fire) begin
                            n_cur_hours = next_hours(r_cur_hours);
                            wr_h        = 1'b1;
                        end
                    end else begin
                        n_hours_hold = 8'd0;
                    end
                    if (in_item.minutes_button) begin
                        n_minutes_hold = minutes_step.count;
                        if (minutes_step.fire) begin
                            n_cur_minutes = next_minutes(r_cur_minutes);
                            wr_m          = 1'b1;
                        end
                    end else begin
                        n_minutes_hold = 8'd0;
                    end
                end
            end
        end
    end

    // result of the accepted transaction
    always_comb begin
        n_out_item.hours_bcd     = n_cur_hours;
        n_out_item.minutes_bcd   = n_cur_minutes;
        n_out_item.dot_on        = (n_sub_millis >= DOT_THRESHOLD);
        n_out_item.write_hours   = wr_h;
        n_out_item.write_minutes = wr_m;
        n_out_item.clear_seconds = clr_s;
    end

    always_comb begin
        if (in_fire) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_millis   <= '0;
            r_sub_micros   <= '0;
            r_sub_nanos    <= '0;
            r_cur_hours    <= '0;
            r_cur_minutes  <= '0;
            r_hours_hold   <= '0;
            r_minutes_hold <= '0;
            r_both_hold    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_sub_millis   <= n_sub_millis;
            r_sub_micros   <= n_sub_micros;
            r_sub_nanos    <= n_sub_nanos;
            r_cur_hours    <= n_cur_hours;
            r_cur_minutes  <= n_cur_minutes;
            r_hours_hold   <= n_hours_hold;
            r_minutes_hold <= n_minutes_hold;
            r_both_hold    <= n_both_hold;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload register, loaded only with a new transaction
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule
